@@ sv/slr_pkg.sv @@
// Shared types and constants of the shuffled Lehmer random generator.
package slr_pkg;

    // Minimal-standard Lehmer constants.
    localparam logic [31:0] LEHMER_MOD   = 32'd2147483647;
    localparam logic [16:0] LEHMER_MUL   = 17'd16807;

    // Extra generator steps run ahead of the table fill.
    localparam int          WARMUP_EXTRA = 8;

    // Shift of the reciprocal used for the slot division.
    localparam int          RECIP_SHIFT  = 32;

    // Operand selection of the shared multiplier.
    localparam logic [2:0]  MUL_NONE     = 3'd0;
    localparam logic [2:0]  MUL_LEHMER   = 3'd1;
    localparam logic [2:0]  MUL_RECIP    = 3'd2;
    localparam logic [2:0]  MUL_NDIV     = 3'd3;
    localparam logic [2:0]  MUL_SPAN_LO  = 3'd4;
    localparam logic [2:0]  MUL_SPAN_HI  = 3'd5;

    // Input word.
    typedef struct packed {
        logic               func;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic        [30:0] raw_value;
        logic signed [31:0] ranged_value;
        logic               range_error;
        logic        [30:0] current_seed;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_in;
        logic       seed_load;
        logic       seed_step;
        logic [2:0] mul_sel;
        logic       q_load;
        logic       slot_load;
        logic       ram_we;
        logic       ram_fill;
        logic       last_fill;
        logic       raw_load;
        logic       acc_init;
        logic       acc_add;
        logic       sum_load;
        logic       out_load;
    } cmd_t;

endpackage

@@ sv/slr_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module slr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/slr_ctrl.sv @@
// Controller state machine that sequences table refill, draw and range mapping.
module slr_ctrl #(
    parameter int TABLE_SIZE = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_func,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          cfg_we,
    output slr_pkg::cmd_t                 cmd,
    output logic [$clog2(TABLE_SIZE)-1:0] fill_idx
);
    import slr_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam int CNT_W  = $clog2(TABLE_SIZE + WARMUP_EXTRA);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_FILL_LOAD = 4'd1;
    localparam logic [3:0] S_FILL_MUL  = 4'd2;
    localparam logic [3:0] S_FILL_RED  = 4'd3;
    localparam logic [3:0] S_SLOT1     = 4'd4;
    localparam logic [3:0] S_SLOT2     = 4'd5;
    localparam logic [3:0] S_SLOT3     = 4'd6;
    localparam logic [3:0] S_READ      = 4'd7;
    localparam logic [3:0] S_SWAP      = 4'd8;
    localparam logic [3:0] S_MAP1      = 4'd9;
    localparam logic [3:0] S_MAP2      = 4'd10;
    localparam logic [3:0] S_MAP3      = 4'd11;
    localparam logic [3:0] S_MAP4      = 4'd12;
    localparam logic [3:0] S_DONE      = 4'd13;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             table_ready_reg, table_ready_next;
    logic             func_reg, func_next;
    logic             out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign fill_idx  = cnt_reg[SLOT_W-1:0];

    // Next state and datapath commands.
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        table_ready_next = table_ready_reg;
        func_next        = func_reg;
        cmd              = '0;
        cmd.mul_sel      = MUL_NONE;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    func_next   = in_func;
                    state_next  = table_ready_reg ? S_SLOT1 : S_FILL_LOAD;
                end
            end
            S_FILL_LOAD:
            begin
                cmd.seed_load = 1'b1;
                cnt_next      = CNT_W'(TABLE_SIZE + WARMUP_EXTRA - 1);
                state_next    = S_FILL_MUL;
            end
            S_FILL_MUL:
            begin
                cmd.mul_sel = MUL_LEHMER;
                state_next  = S_FILL_RED;
            end
            S_FILL_RED:
            begin
                cmd.seed_step = 1'b1;
                cmd.ram_fill  = 1'b1;
                cmd.ram_we    = (cnt_reg < CNT_W'(TABLE_SIZE));
                if (cnt_reg == '0)
                begin
                    cmd.last_fill    = 1'b1;
                    table_ready_next = 1'b1;
                    state_next       = S_SLOT1;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = S_FILL_MUL;
                end
            end
            S_SLOT1:
            begin
                cmd.mul_sel = MUL_RECIP;
                state_next  = S_SLOT2;
            end
            S_SLOT2:
            begin
                cmd.mul_sel = MUL_NDIV;
                cmd.q_load  = 1'b1;
                state_next  = S_SLOT3;
            end
            S_SLOT3:
            begin
                cmd.slot_load = 1'b1;
                cmd.mul_sel   = MUL_LEHMER;
                state_next    = S_READ;
            end
            S_READ:
            begin
                cmd.seed_step = 1'b1;
                state_next    = S_SWAP;
            end
            S_SWAP:
            begin
                cmd.raw_load = 1'b1;
                cmd.ram_we   = 1'b1;
                state_next   = func_reg ? S_MAP1 : S_DONE;
            end
            S_MAP1:
            begin
                cmd.mul_sel = MUL_SPAN_LO;
                state_next  = S_MAP2;
            end
            S_MAP2:
            begin
                cmd.acc_init = 1'b1;
                cmd.mul_sel  = MUL_SPAN_HI;
                state_next   = S_MAP3;
            end
            S_MAP3:
            begin
                cmd.acc_add = 1'b1;
                state_next  = S_MAP4;
            end
            S_MAP4:
            begin
                cmd.sum_load = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A seed write forces a refill before the next draw.
        if (cfg_we)
        begin
            table_ready_next = 1'b0;
        end
    end

    // Output word valid flag.
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            table_ready_reg <= 1'b0;
            func_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            table_ready_reg <= table_ready_next;
            func_reg        <= func_next;
            out_valid_reg   <= out_valid_next;
        end
    end

endmodule

@@ sv/slr_dp.sv @@
// Datapath with the shared multiplier, Mersenne reduction, shuffle table and range mapping.
module slr_dp #(
    parameter int TABLE_SIZE = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  slr_pkg::cmd_t                 cmd,
    input  logic [$clog2(TABLE_SIZE)-1:0] fill_idx,
    input  slr_pkg::in_word_t             in_data,
    input  logic                          cfg_we,
    input  logic [30:0]                   cfg_data,
    output slr_pkg::out_word_t            out_data
);
    import slr_pkg::*;

    localparam int          SLOT_W  = $clog2(TABLE_SIZE);
    localparam int          Q_W     = $clog2(TABLE_SIZE + 1);
    localparam longint      NDIV    = 64'd1 + (64'd2147483646 / TABLE_SIZE);
    localparam longint      RECIP_M = (64'd1 << RECIP_SHIFT) / NDIV;
    localparam logic [31:0] NDIV_W  = NDIV[31:0];
    localparam logic [16:0] RECIP_W = RECIP_M[16:0];
    localparam logic [Q_W:0] SLOT_MAX = (Q_W + 1)'(TABLE_SIZE - 1);

    logic [30:0]       seed_value_reg;
    logic [30:0]       seed_reg;
    logic [30:0]       last_reg;
    logic [30:0]       raw_reg;
    logic [47:0]       prod_reg;
    logic [Q_W-1:0]    q_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [63:0]       acc_reg;
    logic [33:0]       sum_reg;
    logic [32:0]       span_reg;
    logic              err_reg;
    in_word_t          in_reg;
    out_word_t         out_reg;

    logic [30:0]       mul_a;
    logic [16:0]       mul_b;
    logic [31:0]       red_sum;
    logic [31:0]       red_sub;
    logic [30:0]       new_seed;
    logic [Q_W-1:0]    q0;
    logic [31:0]       rem;
    logic [Q_W:0]      q_fix;
    logic [SLOT_W-1:0] slot_next;
    logic [33:0]       diff;
    logic [33:0]       high_ext;
    logic [31:0]       capped;
    logic [30:0]       ram_rdata;
    logic [SLOT_W-1:0] ram_waddr;
    logic [30:0]       ram_wdata;

    // Shared multiplier operand selection.
    assign q0 = prod_reg[RECIP_SHIFT +: Q_W];

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_LEHMER:
            begin
                mul_a = seed_reg;
                mul_b = LEHMER_MUL;
            end
            MUL_RECIP:
            begin
                mul_a = last_reg;
                mul_b = RECIP_W;
            end
            MUL_NDIV:
            begin
                mul_a = NDIV_W[30:0];
                mul_b = {{(17 - Q_W){1'b0}}, q0};
            end
            MUL_SPAN_LO:
            begin
                mul_a = raw_reg;
                mul_b = {1'b0, span_reg[15:0]};
            end
            MUL_SPAN_HI:
            begin
                mul_a = raw_reg;
                mul_b = span_reg[32:16];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Reduction modulo 2^31-1 of the product: fold the high part, then one subtract.
    assign red_sum  = {1'b0, prod_reg[30:0]} + {17'd0, prod_reg[45:31]};
    assign red_sub  = red_sum - LEHMER_MOD;
    assign new_seed = (red_sum >= LEHMER_MOD) ? red_sub[30:0] : red_sum[30:0];

    // Slot from the reciprocal quotient with a one-step correction, capped at the top slot.
    assign rem   = {1'b0, last_reg} - prod_reg[31:0];
    assign q_fix = {1'b0, q_reg} + ((rem >= NDIV_W) ? (Q_W + 1)'(1) : (Q_W + 1)'(0));
    assign slot_next = (q_fix > SLOT_MAX) ? SLOT_MAX[SLOT_W-1:0] : q_fix[SLOT_W-1:0];

    // Span and range check of the captured bounds.
    assign diff = {{2{in_reg.range_high[31]}}, in_reg.range_high}
                - {{2{in_reg.range_low[31]}}, in_reg.range_low} + 34'd1;
    assign high_ext = {{2{in_reg.range_high[31]}}, in_reg.range_high};
    assign capped   = ($signed(sum_reg) > $signed(high_ext)) ? in_reg.range_high : sum_reg[31:0];

    // Shuffle table.
    assign ram_waddr = cmd.ram_fill ? fill_idx : slot_reg;
    assign ram_wdata = cmd.ram_fill ? new_seed : seed_reg;

    slr_ram #(
        .WIDTH (31),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (cmd.ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // Seed register and generator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_value_reg <= 31'd1;
            seed_reg       <= 31'd1;
        end
        else
        begin
            if (cfg_we)
            begin
                seed_value_reg <= cfg_data;
                seed_reg       <= cfg_data;
            end
            else if (cmd.seed_load)
            begin
                seed_reg <= seed_value_reg;
            end
            else if (cmd.seed_step)
            begin
                seed_reg <= new_seed;
            end
        end
    end

    // Working registers of a draw.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= in_data;
        end
        span_reg <= diff[32:0];
        err_reg  <= ($signed(in_reg.range_high) < $signed(in_reg.range_low));
        if (cmd.mul_sel != MUL_NONE)
        begin
            prod_reg <= {17'd0, mul_a} * {31'd0, mul_b};
        end
        if (cmd.q_load)
        begin
            q_reg <= q0;
        end
        if (cmd.slot_load)
        begin
            slot_reg <= slot_next;
        end
        if (cmd.last_fill)
        begin
            last_reg <= new_seed;
        end
        else if (cmd.raw_load)
        begin
            last_reg <= ram_rdata;
        end
        if (cmd.raw_load)
        begin
            raw_reg <= ram_rdata;
        end
        if (cmd.acc_init)
        begin
            acc_reg <= {16'd0, prod_reg};
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + {prod_reg, 16'd0};
        end
        if (cmd.sum_load)
        begin
            sum_reg <= {{2{in_reg.range_low[31]}}, in_reg.range_low} + {1'b0, acc_reg[63:31]};
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.raw_value    <= raw_reg;
            out_reg.current_seed <= seed_reg;
            out_reg.range_error  <= in_reg.func & err_reg;
            if (!in_reg.func)
            begin
                out_reg.ranged_value <= '0;
            end
            else if (err_reg)
            begin
                out_reg.ranged_value <= '1;
            end
            else
            begin
                out_reg.ranged_value <= capped;
            end
        end
    end

    assign out_data = out_reg;

endmodule

@@ sv/shuffled_lehmer_random.sv @@
// Top level of the shuffled minimal-standard Lehmer random generator.
//
// Each accepted word yields one result word: the next value of a 16807*seed mod (2^31-1)
// generator passed through a TABLE_SIZE-entry shuffle table, the generator seed after the
// draw, and, when func is 1, that value mapped into [range_low, range_high] (range_error and
// -1 when the bounds are inverted). A raw draw runs the slot division, the table read and the
// swap, and a mapped draw adds the range multiply in two halves; all multiplications share
// one 31x17 multiplier. The first draw after reset or after a seed write first refills the
// table, after the WARMUP_EXTRA warm-up steps of the generator. A new word is taken once the
// previous result sits in the output register, even while it still waits to be taken.
module shuffled_lehmer_random #(
    parameter int TABLE_SIZE = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  slr_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output slr_pkg::out_word_t out_data,
    input  logic               cfg_we,
    input  logic [30:0]        cfg_data
);
    import slr_pkg::*;

    cmd_t                          cmd;
    logic [$clog2(TABLE_SIZE)-1:0] fill_idx;

    // Sequencer.
    slr_ctrl #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_func   (in_data.func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cmd       (cmd),
        .fill_idx  (fill_idx)
    );

    // Arithmetic and table.
    slr_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .fill_idx (fill_idx),
        .in_data  (in_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .out_data (out_data)
    );

endmodule
